// File: hw/rtl/periodic_day_dates_in_month_defines.svh
// Assertion macros shared by the checker of the periodic day-date block.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef PERIODIC_DAY_DATES_IN_MONTH_DEFINES_SVH
`define PERIODIC_DAY_DATES_IN_MONTH_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while reset is applied.
`define PDDM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is applied.
`define PDDM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pddm_pkg.sv
// Package of the periodic day-date block: field widths, calendar constants,
// sequencer states, shared-unit control types and the month length function.
// Depends on nothing.
package pddm_pkg;

	// Fixed field widths.
	localparam int DAY_W    = 10;  // holds a day plus the largest period
	localparam int HIT_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int PERIOD_W = 9;
	localparam int LEN_W    = 5;

	// Calendar constants.
	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR  = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN  = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP  = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV  = 4'd11;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
	localparam int CENTURY      = 100;
	localparam int CENTURY_LAST = 99;
	localparam logic [LEN_W-1:0] LEN_28 = 5'd28;
	localparam logic [LEN_W-1:0] LEN_29 = 5'd29;
	localparam logic [LEN_W-1:0] LEN_30 = 5'd30;
	localparam logic [LEN_W-1:0] LEN_31 = 5'd31;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_TEST,
		ST_ADD,
		ST_NORM
	} seq_state_t;

	// Control and status of the shared add/subtract unit.
	typedef struct packed {
		logic sub;
	} alu_ctl_t;

	typedef struct packed {
		logic borrow;
		logic zero;
	} alu_flag_t;

	// Days in a month; months out of range count as 31 days.
	function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [LEN_W-1:0] len;
		case (m) inside
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
			MON_FEB: len = leap ? LEN_29 : LEN_28;
			default: len = LEN_31;
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/pddm_alu.sv
// Shared add/subtract unit of the periodic day-date block.
// Depends on pddm_pkg for its control and flag types.
module pddm_alu import pddm_pkg::*; #(
	parameter int W = 13
) (
	input  alu_ctl_t       ctl,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [W-1:0]   res,
	output alu_flag_t      flag
);

	logic [W:0] wide;

	// One adder serves both directions; a subtract adds the complement plus one.
	assign wide = {1'b0, a} + {1'b0, (ctl.sub ? ~b : b)} + (W + 1)'(ctl.sub);
	assign res  = wide[W-1:0];

	// Without a carry out a subtract has borrowed.
	assign flag.borrow = ctl.sub & ~wide[W];
	assign flag.zero   = (wide[W-1:0] == '0);

endmodule

// File: hw/rtl/periodic_day_dates_in_month.sv
// Top level of the periodic day-date block; depends on pddm_pkg and pddm_alu.
// A zero period is answered in the cycle after the request. Otherwise the prep state strips
// centuries from start_year, then each period step visits the test and add states, then the
// norm state once per month boundary crossed plus once; each day leaves one step later.
// Throughput: one request at a time; busy falls in the cycle the last result is strobed.
// Reset: arst_n clears the sequencer and the result strobe; the receiver cannot stall.
module periodic_day_dates_in_month import pddm_pkg::*; #(
	parameter int YEAR_BITS  = 12,
	parameter int MAX_PERIOD = 365
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [HIT_W-1:0]      start_day,
	input  logic [MONTH_W-1:0]    start_month,
	input  logic [YEAR_BITS-1:0]  start_year,
	input  logic [PERIOD_W-1:0]   period_days,
	input  logic [MONTH_W-1:0]    target_month,
	input  logic [YEAR_BITS-1:0]  target_year,
	output logic                  result_valid,
	output logic [HIT_W-1:0]      hit_day,
	output logic                  has_date,
	output logic                  last_of_run,
	output logic                  bad_period
);

	// The walk may run one year past the target, so the year gets a spare bit.
	localparam int YW    = YEAR_BITS + 1;
	localparam int ALU_W = (YW > DAY_W) ? YW : DAY_W;
	localparam logic [PERIOD_W-1:0] PERIOD_CAP =
		(MAX_PERIOD >= (1 << PERIOD_W)) ? {PERIOD_W{1'b1}} : PERIOD_W'(MAX_PERIOD);

	seq_state_t state_q, state_d;

	logic [DAY_W-1:0]     day_q;
	logic [MONTH_W-1:0]   month_q;
	logic [YW-1:0]        year_q;
	logic [YEAR_BITS-1:0] rem_q;
	logic [1:0]           cent_q;
	logic [PERIOD_W-1:0]  per_q;
	logic [MONTH_W-1:0]   tmon_q;
	logic [YEAR_BITS-1:0] tyear_q;
	logic [HIT_W-1:0]     pend_q;
	logic                 pend_vld_q;

	logic                 result_valid_q;
	logic [HIT_W-1:0]     hit_day_q;
	logic                 has_date_q;
	logic                 last_q;
	logic                 bad_q;

	alu_ctl_t             alu_ctl;
	alu_flag_t            alu_flag;
	logic [ALU_W-1:0]     alu_a;
	logic [ALU_W-1:0]     alu_b;
	logic [ALU_W-1:0]     alu_res;

	logic                 leap;
	logic [LEN_W-1:0]     mlen;
	logic                 earlier;
	logic                 in_target;
	logic                 accept;
	logic                 zero_period;
	logic                 seeking;

	assign accept      = start && (state_q == ST_IDLE);
	assign zero_period = (period_days == '0);
	assign busy        = (state_q != ST_IDLE);

	// Leap rule from the low year bits and the century split kept beside the year.
	assign leap = (year_q[1:0] == 2'b00) && ((rem_q != '0) || (cent_q == 2'b00));
	assign mlen = month_len(month_q, leap);

	// Date order against day 1 of the target month, and membership in that month.
	always_comb begin
		if (year_q != YW'(tyear_q)) begin
			earlier = (year_q < YW'(tyear_q));
		end else if (month_q != tmon_q) begin
			earlier = (month_q < tmon_q);
		end else begin
			earlier = (day_q == '0);
		end
	end

	assign in_target = (year_q == YW'(tyear_q)) && (month_q == tmon_q);
	assign seeking   = !pend_vld_q && earlier;

	// Operand selection for the shared unit.
	always_comb begin
		case (state_q)
			ST_PREP: begin
				alu_a   = ALU_W'(rem_q);
				alu_b   = ALU_W'(CENTURY);
				alu_ctl = '{sub: 1'b1};
			end
			ST_ADD: begin
				alu_a   = ALU_W'(day_q);
				alu_b   = ALU_W'(per_q);
				alu_ctl = '{sub: 1'b0};
			end
			ST_NORM: begin
				alu_a   = ALU_W'(day_q);
				alu_b   = ALU_W'(mlen);
				alu_ctl = '{sub: 1'b1};
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_ctl = '{sub: 1'b0};
			end
		endcase
	end

	pddm_alu #(
		.W (ALU_W)
	) u_alu (
		.ctl  (alu_ctl),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.flag (alu_flag)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !zero_period) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (alu_flag.borrow) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (seeking || in_target) begin
					state_d = ST_ADD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD: begin
				state_d = ST_NORM;
			end
			ST_NORM: begin
				if (alu_flag.borrow || alu_flag.zero) begin
					state_d = ST_TEST;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control flags: held day marker and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pend_vld_q <= 1'b0;
					if (accept && zero_period) begin
						result_valid_q <= 1'b1;
					end
				end
				ST_TEST: begin
					if (!seeking) begin
						if (in_target) begin
							pend_vld_q     <= 1'b1;
							result_valid_q <= pend_vld_q;
						end else begin
							result_valid_q <= 1'b1;
						end
					end
				end
				default: begin
					pend_vld_q <= pend_vld_q;
				end
			endcase
		end
	end

	// Walk registers and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					day_q   <= DAY_W'(start_day);
					month_q <= start_month;
					year_q  <= YW'(start_year);
					rem_q   <= start_year;
					cent_q  <= 2'b00;
					per_q   <= (int'(period_days) > MAX_PERIOD) ? PERIOD_CAP : period_days;
					tmon_q  <= target_month;
					tyear_q <= target_year;
					if (zero_period) begin
						hit_day_q  <= '0;
						has_date_q <= 1'b0;
						last_q     <= 1'b1;
						bad_q      <= 1'b1;
					end
				end
			end
			ST_PREP: begin
				// Strip one century a cycle to find the year within its century.
				if (!alu_flag.borrow) begin
					rem_q  <= alu_res[YEAR_BITS-1:0];
					cent_q <= cent_q + 2'd1;
				end
			end
			ST_TEST: begin
				// A day is held one step so that the final one can be marked last.
				if (!seeking) begin
					if (in_target) begin
						pend_q     <= day_q[HIT_W-1:0];
						hit_day_q  <= pend_q;
						has_date_q <= 1'b1;
						last_q     <= 1'b0;
						bad_q      <= 1'b0;
					end else begin
						hit_day_q  <= pend_vld_q ? pend_q : '0;
						has_date_q <= pend_vld_q;
						last_q     <= 1'b1;
						bad_q      <= 1'b0;
					end
				end
			end
			ST_ADD: begin
				day_q <= alu_res[DAY_W-1:0];
			end
			ST_NORM: begin
				// Carry whole months out of the day count, rolling the year after December.
				if (!alu_flag.borrow && !alu_flag.zero) begin
					day_q <= alu_res[DAY_W-1:0];
					if (month_q >= DECEMBER) begin
						month_q <= JANUARY;
						year_q  <= year_q + YW'(1);
						if (rem_q == YEAR_BITS'(CENTURY_LAST)) begin
							rem_q  <= '0;
							cent_q <= cent_q + 2'd1;
						end else begin
							rem_q <= rem_q + YEAR_BITS'(1);
						end
					end else begin
						month_q <= month_q + MONTH_W'(1);
					end
				end
			end
			default: begin
				day_q <= day_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign hit_day      = hit_day_q;
	assign has_date     = has_date_q;
	assign last_of_run  = last_q;
	assign bad_period   = bad_q;

endmodule

// File: hw/rtl/pddm_checker.sv
// Port-level checker of the periodic day-date block and its bind to the top level.
// Depends on pddm_pkg and on the assertion macros in the defines header.
`include "periodic_day_dates_in_month_defines.svh"

module pddm_checker import pddm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [PERIOD_W-1:0] period_days,
	input logic                result_valid,
	input logic [HIT_W-1:0]    hit_day,
	input logic                has_date,
	input logic                last_of_run,
	input logic                bad_period
);

	// A zero-period request ends at once with a single empty flagged result.
	`PDDM_ASSERT_IMP(a_bad_shape, result_valid && bad_period, !has_date && last_of_run && (hit_day == '0), "flagged result is not an empty final one")

	// An empty result always closes its request and carries no day.
	`PDDM_ASSERT_IMP(a_empty_last, result_valid && !has_date, last_of_run && (hit_day == '0), "empty result is not final")

	// A listed day is a real day of the month and never flagged.
	`PDDM_ASSERT_IMP(a_day_nonzero, result_valid && has_date, (hit_day != '0) && !bad_period, "listed day is zero or flagged")

	// A valid-period request starts the walk on the next cycle.
	`PDDM_ASSERT_NXT(a_walk_starts, start && !busy && (period_days != '0), busy, "walk did not start")

	// A zero-period request is answered on the next cycle.
	`PDDM_ASSERT_NXT(a_bad_answer, start && !busy && (period_days == '0), result_valid && bad_period, "zero period not answered")

endmodule

bind periodic_day_dates_in_month pddm_checker u_pddm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.period_days  (period_days),
	.result_valid (result_valid),
	.hit_day      (hit_day),
	.has_date     (has_date),
	.last_of_run  (last_of_run),
	.bad_period   (bad_period)
);
